// ===== rtl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and helpers for the hex record loader.
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

  localparam int LPOS_W = 10;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;

  localparam int POS_COUNT_LAST = 2;
  localparam int POS_ADDR_LAST  = 6;
  localparam int POS_HDR_END    = 9;
  localparam int POS_EXT_END    = 13;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_SEGMENT = 8'h02;
  localparam logic [7:0] REC_LINEAR  = 8'h04;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_EXT    = 2'd2,
    MODE_SKIP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_MEMORY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_CODE_BASE   = 3'd0,
    REG_CODE_SIZE   = 3'd1,
    REG_CODE_ENABLE = 3'd2,
    REG_DATA_BASE   = 3'd3,
    REG_DATA_SIZE   = 3'd4,
    REG_DATA_ENABLE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] code_base;
    logic [31:0] code_size;
    logic        code_enable;
    logic [31:0] data_base;
    logic [31:0] data_size;
    logic        data_enable;
  } cfg_t;

  typedef struct packed {
    logic        hit;
    logic        region;
    logic        enabled;
    logic [31:0] offset;
  } win_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
        t = c - CH_ZERO;
        hex_digit = t[4:0];
      end else if (c >= CH_UPPER && c <= CH_UPPER + 8'd5) begin
        t = c - CH_UPPER + 8'd10;
        hex_digit = t[4:0];
      end else if (c >= CH_LOWER && c <= CH_LOWER + 8'd5) begin
        t = c - CH_LOWER + 8'd10;
        hex_digit = t[4:0];
      end else begin
        hex_digit = 5'h10;
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ihex_in_if.sv =====
// ----------------------------------------------------------------------------
// ihex_in_if
// Character stream channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_file;

  modport source (output valid, character, end_of_file, input ready);
  modport sink   (input valid, character, end_of_file, output ready);
endinterface

`default_nettype wire

// ===== rtl/ihex_out_if.sv =====
// ----------------------------------------------------------------------------
// ihex_out_if
// Result channel: byte writes and end-of-file reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        region;
  logic [31:0] offset;
  logic [7:0]  value;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, kind, region, offset, value, status, last_of_run,
                  input ready);
  modport sink   (input valid, kind, region, offset, value, status, last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ihex_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ihex_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihex_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ihex_window.sv =====
// ----------------------------------------------------------------------------
// ihex_window
// Registered code/data window check for the record header in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_window import ihex_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  wire logic        clk,
  input  wire cfg_t        cfg,
  input  wire logic [15:0] address_field,
  input  wire logic [31:0] extension_base,
  input  wire logic [7:0]  byte_count,
  output win_t             win
);

  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

  logic [32:0] sum;
  logic [31:0] addr;
  logic [32:0] end_addr;
  logic [32:0] code_lim;
  logic [32:0] data_lim;
  logic        code_hit;
  logic        data_hit;

  always_comb begin
    sum      = {17'd0, address_field} + {1'b0, extension_base};
    addr     = sum[31:0] & ADDR_MASK;
    end_addr = {1'b0, addr} + {25'd0, byte_count};
    code_lim = {1'b0, cfg.code_base} + {1'b0, cfg.code_size};
    data_lim = {1'b0, cfg.data_base} + {1'b0, cfg.data_size};
    code_hit = code_lim >= end_addr;
    data_hit = (cfg.data_base <= addr) && (data_lim >= end_addr);
  end

  always_ff @(posedge clk) begin
    win.hit <= code_hit || data_hit;
    if (code_hit) begin
      win.region  <= 1'b0;
      win.enabled <= cfg.code_enable;
      win.offset  <= addr - cfg.code_base;
    end else begin
      win.region  <= 1'b1;
      win.enabled <= cfg.data_enable;
      win.offset  <= addr - cfg.data_base;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/intel_hex_record_loader_core.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_loader_core
// Hex record parser: one character per transfer, byte writes and reports out.
// ----------------------------------------------------------------------------
// A result is registered and shows in the cycle after its character transfer.
// Throughput: one character per cycle; the output register holds one result
// and the input is taken whenever that register is empty or being drained.
// Window check is registered off the header fields, ahead of the type digits.
// Reset: synchronous; parser state, status and registers return to defaults.
`default_nettype none

module intel_hex_record_loader_core import ihex_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  ihex_cfg_if.sink  cfg,
  ihex_in_if.sink   rx,
  ihex_out_if.source tx
);

  cfg_t cfg_regs;
  win_t win;

  logic [LPOS_W-1:0] line_position, line_position_next;
  logic [7:0]        record_kind, record_kind_next;
  logic [7:0]        byte_count, byte_count_next;
  logic [15:0]       address_field, address_field_next;
  logic [31:0]       extension_base, extension_base_next;
  logic [31:0]       write_offset, write_offset_next;
  logic              target_region, target_region_next;
  mode_t             line_mode, line_mode_next;
  logic [3:0]        high_nibble, high_nibble_next;
  status_t           sticky_status, sticky_status_next;
  logic              nibble_bad, nibble_bad_next;

  logic        rx_xfer;
  logic [4:0]  digit;
  logic        bad;
  logic [3:0]  nib;
  logic        res_valid;
  logic        res_kind;
  logic        res_region;
  logic [31:0] res_offset;
  logic [7:0]  res_value;
  status_t     res_status;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !tx.valid || tx.ready;
  assign rx_xfer   = rx.valid && rx.ready;
  assign digit     = hex_digit(rx.character);
  assign bad       = digit[4];
  assign nib       = digit[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '{code_base: 32'd0, code_size: 32'd0, code_enable: 1'b1,
                    data_base: 32'd0, data_size: 32'd0, data_enable: 1'b1};
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CODE_BASE:   cfg_regs.code_base   <= cfg.data;
        REG_CODE_SIZE:   cfg_regs.code_size   <= cfg.data;
        REG_CODE_ENABLE: cfg_regs.code_enable <= cfg.data[0];
        REG_DATA_BASE:   cfg_regs.data_base   <= cfg.data;
        REG_DATA_SIZE:   cfg_regs.data_size   <= cfg.data;
        REG_DATA_ENABLE: cfg_regs.data_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  ihex_window #(.ADDR_BITS(ADDR_BITS)) u_window (
    .clk            (clk),
    .cfg            (cfg_regs),
    .address_field  (address_field),
    .extension_base (extension_base),
    .byte_count     (byte_count),
    .win            (win)
  );

  // next state
  always_comb begin
    line_position_next  = line_position;
    record_kind_next    = record_kind;
    byte_count_next     = byte_count;
    address_field_next  = address_field;
    extension_base_next = extension_base;
    write_offset_next   = write_offset;
    target_region_next  = target_region;
    line_mode_next      = line_mode;
    high_nibble_next    = high_nibble;
    sticky_status_next  = sticky_status;
    nibble_bad_next     = nibble_bad;

    if (rx.end_of_file) begin
      line_position_next  = '0;
      record_kind_next    = 8'd0;
      byte_count_next     = 8'd0;
      address_field_next  = 16'd0;
      extension_base_next = 32'd0;
      write_offset_next   = 32'd0;
      target_region_next  = 1'b0;
      line_mode_next      = MODE_HEADER;
      high_nibble_next    = 4'd0;
      sticky_status_next  = ST_OK;
      nibble_bad_next     = 1'b0;
    end else if (sticky_status != ST_OK) begin
      // dropped until end of file
    end else if (rx.character == CH_LF) begin
      if (line_mode != MODE_SKIP) sticky_status_next = ST_FORMAT;
      line_position_next = '0;
      line_mode_next     = MODE_HEADER;
      high_nibble_next   = 4'd0;
      nibble_bad_next    = 1'b0;
    end else begin
      unique case (line_mode)
        MODE_HEADER: begin
          if (line_position == '0 && rx.character != CH_COLON) begin
            sticky_status_next = ST_FORMAT;
          end else if (line_position != '0 && bad) begin
            sticky_status_next = ST_FORMAT;
          end else begin
            if (line_position != '0) begin
              priority if (line_position <= LPOS_W'(POS_COUNT_LAST)) begin
                byte_count_next = {byte_count[3:0], nib};
              end else if (line_position <= LPOS_W'(POS_ADDR_LAST)) begin
                address_field_next = {address_field[11:0], nib};
              end else begin
                record_kind_next = {record_kind[3:0], nib};
              end
            end
            line_position_next = line_position + 1'b1;
            if (line_position == LPOS_W'(POS_HDR_END - 1)) begin
              priority if (record_kind_next == REC_SEGMENT ||
                           record_kind_next == REC_LINEAR) begin
                write_offset_next = 32'd0;
                line_mode_next    = MODE_EXT;
              end else if (record_kind_next != REC_DATA) begin
                line_mode_next = MODE_SKIP;
              end else if (!win.hit) begin
                sticky_status_next = ST_MEMORY;
              end else begin
                target_region_next = win.region;
                write_offset_next  = win.offset;
                line_mode_next     = (win.enabled && byte_count != 8'd0) ?
                                     MODE_DATA : MODE_SKIP;
              end
            end
          end
        end
        MODE_EXT: begin
          if (bad) begin
            sticky_status_next = ST_FORMAT;
          end else begin
            write_offset_next  = {16'd0, write_offset[11:0], nib};
            line_position_next = line_position + 1'b1;
            if (line_position == LPOS_W'(POS_EXT_END - 1)) begin
              extension_base_next = (record_kind == REC_LINEAR) ?
                {write_offset[11:0], nib, 16'd0} :
                {12'd0, write_offset[11:0], nib, 4'd0};
              write_offset_next = 32'd0;
              line_mode_next    = MODE_SKIP;
            end
          end
        end
        MODE_DATA: begin
          if (line_position[0]) begin
            nibble_bad_next  = bad;
            high_nibble_next = nib;
          end else begin
            write_offset_next = write_offset + 32'd1;
            byte_count_next   = byte_count - 8'd1;
            if (byte_count == 8'd1) line_mode_next = MODE_SKIP;
          end
          line_position_next = line_position + 1'b1;
        end
        MODE_SKIP: ;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid  = 1'b0;
    res_kind   = KIND_WRITE;
    res_region = 1'b0;
    res_offset = 32'd0;
    res_value  = 8'd0;
    res_status = ST_OK;
    if (rx.end_of_file) begin
      res_valid  = 1'b1;
      res_kind   = KIND_REPORT;
      res_status = sticky_status;
      if (sticky_status == ST_OK && line_mode != MODE_SKIP &&
          !(line_mode == MODE_HEADER && line_position == '0))
        res_status = ST_FORMAT;
    end else if (sticky_status == ST_OK && rx.character != CH_LF &&
                 line_mode == MODE_DATA && !line_position[0]) begin
      res_valid  = 1'b1;
      res_region = target_region;
      res_offset = write_offset;
      res_value  = (nibble_bad || bad) ? 8'hFF : {high_nibble, nib};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position  <= '0;
      record_kind    <= 8'd0;
      byte_count     <= 8'd0;
      address_field  <= 16'd0;
      extension_base <= 32'd0;
      write_offset   <= 32'd0;
      target_region  <= 1'b0;
      line_mode      <= MODE_HEADER;
      high_nibble    <= 4'd0;
      sticky_status  <= ST_OK;
      nibble_bad     <= 1'b0;
    end else if (rx_xfer) begin
      line_position  <= line_position_next;
      record_kind    <= record_kind_next;
      byte_count     <= byte_count_next;
      address_field  <= address_field_next;
      extension_base <= extension_base_next;
      write_offset   <= write_offset_next;
      target_region  <= target_region_next;
      line_mode      <= line_mode_next;
      high_nibble    <= high_nibble_next;
      sticky_status  <= sticky_status_next;
      nibble_bad     <= nibble_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (rx_xfer) begin
      tx.valid <= res_valid;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_xfer && res_valid) begin
      tx.kind   <= res_kind;
      tx.region <= res_region;
      tx.offset <= res_offset;
      tx.value  <= res_value;
      tx.status <= res_status;
    end
  end

  assign tx.last_of_run = 1'b1;

  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.kind == KIND_WRITE) |-> tx.status == ST_OK)
    else $error("byte write carries an error status");

  a_eof_report: assert property (@(posedge clk) disable iff (rst)
    (rx_xfer && rx.end_of_file) |=> (tx.valid && tx.kind == KIND_REPORT))
    else $error("end of file gave no report");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    (rx_xfer && !rx.end_of_file && sticky_status != ST_OK) |=> !tx.valid)
    else $error("result after a sticky error");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    line_mode == MODE_DATA |-> byte_count != 8'd0)
    else $error("data mode with no bytes left");

endmodule

`default_nettype wire

// ===== tb/intel_hex_record_loader_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_loader_checker
// Watches the register, character and result channels of the hex loader,
// decodes the character stream on its own to predict every byte write and
// end-of-file report, and compares each result transfer field by field.
// ----------------------------------------------------------------------------

module intel_hex_record_loader_checker import ihex_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic  clk,
  input  logic  rst,
  ihex_cfg_if   cfg,
  ihex_in_if    rx,
  ihex_out_if   tx,
  output int    failures,
  output int    pending
);

  localparam logic [32:0] ADDR_MASK = (33'd1 << ADDR_BITS) - 33'd1;

  typedef struct packed {
    logic        kind;
    logic        region;
    logic [31:0] offset;
    logic [7:0]  value;
    status_t     status;
    logic        last_of_run;
  } loader_out_t;

  cfg_t              regs;
  logic [LPOS_W-1:0] pos;
  logic [7:0]        rec_type;
  logic [7:0]        count;
  logic [15:0]       addr_fld;
  logic [31:0]       ext_base;
  logic [31:0]       wr_offset;
  logic              region_sel;
  mode_t             mode;
  logic [3:0]        hi_nib;
  logic              hi_bad;
  status_t           status;
  loader_out_t       write_log[$];
  int                err_count = 0;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c inside {[CH_ZERO:CH_ZERO + 8'd9]}) return {1'b0, c[3:0]};
    if (c inside {[CH_UPPER:CH_UPPER + 8'd5], [CH_LOWER:CH_LOWER + 8'd5]})
      return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  task automatic clear_line();
    pos    = '0;
    mode   = MODE_HEADER;
    hi_nib = '0;
    hi_bad = 1'b0;
  endtask

  task automatic clear_parse();
    clear_line();
    rec_type   = '0;
    count      = '0;
    addr_fld   = '0;
    ext_base   = '0;
    wr_offset  = '0;
    region_sel = 1'b0;
    status     = ST_OK;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic eof);
    logic [4:0]  d;
    logic [32:0] abs_addr;
    logic [32:0] rec_end;
    logic        hit;
    logic        win_on;
    loader_out_t r;
    begin
      d      = nibble_of(c);
      r      = '0;
      hit    = 1'b0;
      win_on = 1'b0;
      if (eof) begin
        if (status == ST_OK && mode != MODE_SKIP && !(mode == MODE_HEADER && pos == '0))
          status = ST_FORMAT;
        r.kind        = KIND_REPORT;
        r.status      = status;
        r.last_of_run = 1'b1;
        write_log.push_back(r);
        clear_parse();
      end else if (status != ST_OK) begin
        // sticky error: everything up to end of file is dropped
      end else if (c == CH_LF) begin
        if (mode != MODE_SKIP) status = ST_FORMAT;
        clear_line();
      end else begin
        case (mode)
          MODE_HEADER: begin
            if (pos == '0 && c != CH_COLON) begin
              status = ST_FORMAT;
            end else if (pos != '0 && d[4]) begin
              status = ST_FORMAT;
            end else begin
              if (pos != '0) begin
                if (pos <= LPOS_W'(POS_COUNT_LAST)) count = {count[3:0], d[3:0]};
                else if (pos <= LPOS_W'(POS_ADDR_LAST)) addr_fld = {addr_fld[11:0], d[3:0]};
                else rec_type = {rec_type[3:0], d[3:0]};
              end
              pos = pos + 1'b1;
              if (pos == LPOS_W'(POS_HDR_END)) begin
                if (rec_type == REC_SEGMENT || rec_type == REC_LINEAR) begin
                  wr_offset = '0;
                  mode      = MODE_EXT;
                end else if (rec_type != REC_DATA) begin
                  mode = MODE_SKIP;
                end else begin
                  abs_addr = ({17'd0, addr_fld} + {1'b0, ext_base}) & ADDR_MASK;
                  rec_end  = abs_addr + {25'd0, count};
                  if ({1'b0, regs.code_base} + {1'b0, regs.code_size} >= rec_end) begin
                    region_sel = 1'b0;
                    wr_offset  = abs_addr[31:0] - regs.code_base;
                    win_on     = regs.code_enable;
                    hit        = 1'b1;
                  end else if ({1'b0, regs.data_base} <= abs_addr &&
                               {1'b0, regs.data_base} + {1'b0, regs.data_size} >= rec_end) begin
                    region_sel = 1'b1;
                    wr_offset  = abs_addr[31:0] - regs.data_base;
                    win_on     = regs.data_enable;
                    hit        = 1'b1;
                  end else begin
                    status = ST_MEMORY;
                  end
                  if (hit) mode = (win_on && count != 8'd0) ? MODE_DATA : MODE_SKIP;
                end
              end
            end
          end
          MODE_EXT: begin
            if (d[4]) begin
              status = ST_FORMAT;
            end else begin
              wr_offset = {16'd0, wr_offset[11:0], d[3:0]};
              pos = pos + 1'b1;
              if (pos == LPOS_W'(POS_EXT_END)) begin
                ext_base  = (rec_type == REC_LINEAR) ? {wr_offset[15:0], 16'd0}
                                                      : {12'd0, wr_offset[15:0], 4'd0};
                wr_offset = '0;
                mode      = MODE_SKIP;
              end
            end
          end
          MODE_DATA: begin
            if (pos[0]) begin
              hi_bad = d[4];
              hi_nib = d[3:0];
            end else begin
              r.kind        = KIND_WRITE;
              r.region      = region_sel;
              r.offset      = wr_offset;
              r.value       = (hi_bad || d[4]) ? 8'hFF : {hi_nib, d[3:0]};
              r.status      = ST_OK;
              r.last_of_run = 1'b1;
              write_log.push_back(r);
              wr_offset = wr_offset + 32'd1;
              count     = count - 8'd1;
              if (count == 8'd0) mode = MODE_SKIP;
            end
            pos = pos + 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    loader_out_t exp;
    if (rst) begin
      regs             = '0;
      regs.code_enable = 1'b1;
      regs.data_enable = 1'b1;
      clear_parse();
      write_log.delete();
    end else begin
      if (tx.valid && tx.ready) begin
        if (write_log.size() == 0) begin
          $error("unexpected result: kind %0d region %0d offset 0x%0h value 0x%0h status %0d",
                 tx.kind, tx.region, tx.offset, tx.value, tx.status);
          err_count++;
        end else begin
          exp = write_log.pop_front();
          compare_field("kind", 32'(exp.kind), 32'(tx.kind));
          compare_field("region", 32'(exp.region), 32'(tx.region));
          compare_field("offset", exp.offset, tx.offset);
          compare_field("value", 32'(exp.value), 32'(tx.value));
          compare_field("status", 32'(exp.status), 32'(tx.status));
          compare_field("last_of_run", 32'(exp.last_of_run), 32'(tx.last_of_run));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_CODE_BASE:   regs.code_base   = cfg.data;
          REG_CODE_SIZE:   regs.code_size   = cfg.data;
          REG_CODE_ENABLE: regs.code_enable = cfg.data[0];
          REG_DATA_BASE:   regs.data_base   = cfg.data;
          REG_DATA_SIZE:   regs.data_size   = cfg.data;
          REG_DATA_ENABLE: regs.data_enable = cfg.data[0];
          default: begin
          end
        endcase
      end
      if (rx.valid && rx.ready) decode_char(rx.character, rx.end_of_file);
    end
    pending  <= write_log.size();
    failures <= err_count;
  end

endmodule

// ===== tb/intel_hex_record_loader_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_loader_core_test
// Feeds hex text files to the loader under several window settings: a short
// set of hand-written records and error cases, then random files made mostly
// of well-formed extension and data records aimed at the window edges, with
// some noise and damaged lines. Both ends idle at random bar the last third.
// ----------------------------------------------------------------------------

module intel_hex_record_loader_core_test;
  import ihex_pkg::*;

  localparam int ADDR_BITS      = 32;
  localparam int NUM_SETTINGS   = 6;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PRESSURE_SET   = 1;
  localparam logic [7:0] CH_CR  = 8'h0D;

  logic clk = 1'b0;
  logic rst;

  always #2 clk = ~clk;

  ihex_cfg_if cfg_ch ();
  ihex_in_if  char_ch ();
  ihex_out_if res_ch ();

  int fail_count;
  int pending;

  intel_hex_record_loader_core #(.ADDR_BITS(ADDR_BITS)) DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .rx  (char_ch),
    .tx  (res_ch)
  );

  intel_hex_record_loader_checker #(.ADDR_BITS(ADDR_BITS)) checker_i (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .rx       (char_ch),
    .tx       (res_ch),
    .failures (fail_count),
    .pending  (pending)
  );

  int          items_sent = 0;
  int          base_count = 0;
  int          src_idle_pct = 11;
  int          snk_idle_pct = 59;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  bit          lower_case;
  int          quiet_cycles = 0;
  logic [7:0]  text_q[$];
  logic [7:0]  payload_q[$];
  logic [31:0] set_code_base, set_code_size, set_data_base, set_data_size;

  // result side: random stalls plus one long hold-off
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic eof);
    int phase;
    begin
      phase = (items_sent - base_count) * 3 / RANDOM_ITEMS;
      case (phase)
        0:       begin src_idle_pct = 11; snk_idle_pct = 59; end
        1:       begin src_idle_pct = 59; snk_idle_pct = 11; end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      endcase
      while ($urandom_range(0, 99) < src_idle_pct) begin
        char_ch.valid <= 1'b0;
        @(posedge clk);
      end
      char_ch.valid       <= 1'b1;
      char_ch.character   <= ch;
      char_ch.end_of_file <= eof;
      do @(posedge clk); while (!char_ch.ready);
      items_sent++;
    end
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i], 1'b0);
    text_q.delete();
  endtask

  task automatic end_file(input logic [7:0] eof_char);
    send_text();
    send_item(eof_char, 1'b1);
  endtask

  task automatic wait_idle();
    char_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_setting(input int k);
    bit code_en;
    bit data_en;
    begin
      case (k)
        0: begin
          set_code_base = 32'h0000_0000; set_code_size = 32'h0000_1000; code_en = 1'b1;
          set_data_base = 32'h0000_F000; set_data_size = 32'h0000_1000; data_en = 1'b1;
        end
        1: begin
          set_code_base = 32'h0800_0000; set_code_size = 32'h0004_0000; code_en = 1'b1;
          set_data_base = 32'h2000_0000; set_data_size = 32'h0000_8000; data_en = 1'b1;
        end
        2: begin
          set_code_base = 32'hFFFF_FFFF; set_code_size = 32'hFFFF_FFFF; code_en = 1'b1;
          set_data_base = 32'h0000_0000; set_data_size = 32'h0000_0000; data_en = 1'b0;
        end
        3: begin
          set_code_base = 32'h0000_0000; set_code_size = 32'h0000_0000; code_en = 1'b0;
          set_data_base = 32'h0000_0000; set_data_size = 32'hFFFF_FFFF; data_en = 1'b1;
        end
        4: begin
          set_code_base = 32'h0001_0000; set_code_size = 32'h0000_0100; code_en = 1'b0;
          set_data_base = 32'hFFFF_FF00; set_data_size = 32'h0000_0100; data_en = 1'b1;
        end
        default: begin
          set_code_base = 32'h0000_0000; set_code_size = 32'h0000_2000; code_en = 1'b1;
          set_data_base = 32'h0000_2000; set_data_size = 32'h0000_2000; data_en = 1'b0;
        end
      endcase
      write_reg(REG_CODE_BASE, set_code_base);
      write_reg(REG_CODE_SIZE, set_code_size);
      write_reg(REG_CODE_ENABLE, {31'($urandom), code_en});
      write_reg(REG_DATA_BASE, set_data_base);
      write_reg(REG_DATA_SIZE, set_data_size);
      write_reg(REG_DATA_ENABLE, {31'($urandom), data_en});
      cfg_ch.valid <= 1'b0;
    end
  endtask

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return CH_ZERO + {4'd0, nib};
    return (lower ? CH_LOWER : CH_UPPER) + {4'd0, nib} - 8'd10;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    text_q.push_back(hex_ascii(b[7:4], lower_case));
    text_q.push_back(hex_ascii(b[3:0], lower_case));
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // one record line from payload_q, with a correct checksum
  task automatic push_record(input logic [7:0] rtype, input logic [15:0] addr,
                             input logic [7:0] count_fld);
    logic [7:0] sum;
    begin
      sum = count_fld + addr[15:8] + addr[7:0] + rtype;
      lower_case = 1'($urandom_range(0, 1));
      text_q.push_back(CH_COLON);
      push_byte(count_fld);
      push_byte(addr[15:8]);
      push_byte(addr[7:0]);
      push_byte(rtype);
      foreach (payload_q[i]) begin
        push_byte(payload_q[i]);
        sum = sum + payload_q[i];
      end
      push_byte(8'd0 - sum);
      if ($urandom_range(0, 4) == 0) text_q.push_back(CH_CR);
      text_q.push_back(CH_LF);
      payload_q.delete();
    end
  endtask

  task automatic random_file();
    int          records;
    int          r;
    int          pick;
    int          n;
    int          cut;
    logic [31:0] target;
    logic [15:0] addr;
    bit          broken;
    begin
      records = $urandom_range(1, 5);
      broken  = 1'b0;
      r       = 0;
      while (r < records && !broken) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          n = ($urandom_range(0, 99) < 3) ? $urandom_range(17, 255) : $urandom_range(0, 16);
          case ($urandom_range(0, 4))
            0:       target = set_code_base + $urandom_range(0, 64);
            1:       target = set_code_base + set_code_size - $urandom_range(0, 40);
            2:       target = set_data_base + $urandom_range(0, 64);
            3:       target = set_data_base + set_data_size - $urandom_range(0, 40);
            default: target = $urandom;
          endcase
          addr = target[15:0];
          if ($urandom_range(0, 99) < 75) begin
            if ($urandom_range(0, 3) == 0) begin
              payload_q.push_back(target[19:12]);
              payload_q.push_back(target[11:4]);
              push_record(REC_SEGMENT, 16'h0000, 8'd2);
              addr = {12'd0, target[3:0]};
            end else begin
              payload_q.push_back(target[31:24]);
              payload_q.push_back(target[23:16]);
              push_record(REC_LINEAR, 16'h0000, 8'd2);
            end
          end
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
              0:       payload_q.push_back(8'h00);
              1:       payload_q.push_back(8'hFF);
              default: payload_q.push_back(8'($urandom));
            endcase
          end
          push_record(REC_DATA, addr, 8'(n));
        end else if (pick < 85) begin
          payload_q.push_back(8'($urandom));
          payload_q.push_back(8'($urandom));
          push_record($urandom_range(0, 1) ? REC_LINEAR : REC_SEGMENT,
                      ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'h0000,
                      ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd2);
        end else if (pick < 93) begin
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) payload_q.push_back(8'($urandom));
          case ($urandom_range(0, 3))
            0:       push_record(8'h01, 16'h0000, 8'(n));
            1:       push_record(8'h03, 16'($urandom), 8'(n));
            2:       push_record(8'h05, 16'($urandom), 8'(n));
            default: push_record(8'($urandom_range(6, 255)), 16'($urandom), 8'(n));
          endcase
        end else begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
          text_q.push_back(CH_LF);
          broken = 1'b1;
        end
        if (!broken && $urandom_range(0, 99) < 6) begin
          case ($urandom_range(0, 3))
            0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
            1, 2: begin
              cut = $urandom_range(0, text_q.size() - 1);
              while (text_q.size() > cut) void'(text_q.pop_back());
              if ($urandom_range(0, 1) == 0) text_q.push_back(CH_LF);
            end
            default: text_q.push_front(8'($urandom_range(0, 255)));
          endcase
          broken = 1'b1;
        end
        send_text();
        r++;
      end
      if (!broken && $urandom_range(0, 9) == 0) begin
        text_q.push_back(CH_COLON);
        n = $urandom_range(0, 7);
        for (int i = 0; i < n; i++) text_q.push_back(hex_ascii(4'($urandom), 1'b0));
      end
      end_file(8'($urandom));
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    char_ch.valid       <= 1'b0;
    char_ch.character   <= 8'h00;
    char_ch.end_of_file <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_CODE_BASE;
    cfg_ch.data         <= 32'h0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apply_setting(0);

    // code and data writes, bad data digits, ignored types, empty record,
    // segment and linear bases
    push_str(":0300100012AB3C00\r\n");
    push_str(":02F00000a5ff6a\n");
    push_str(":03000800G1");
    text_q.push_back(8'hFF);
    push_str("57");
    text_q.push_back(8'h00);
    push_str("\n:00000001FF\n:0100000355AA\n:0000000000\n");
    push_str(":020000040000FA\n:0200000200FFFD\n:01000100AB54\n:020000040000fa\n");
    end_file(8'h00);
    // missing colon
    push_str("X:00\n");
    end_file(8'hFF);
    // bad header digit
    push_str(":02001g00\n");
    end_file(8'h41);
    // line ends inside the data bytes
    push_str(":0300000011\n");
    end_file(8'h0A);
    // empty line
    push_str("\n");
    end_file(8'h3A);
    // line ends inside the extension digits
    push_str(":0200000401\n");
    end_file(8'h30);
    // bad extension digit
    push_str(":020000040x00\n");
    end_file(8'h80);
    // end of file inside the header
    push_str(":0180");
    end_file(8'h7F);
    // end of file right after a complete line
    push_str(":00000001FF\n");
    end_file(8'h55);
    // record past the top of the data window
    push_str(":04FFFE0001020304F8\n");
    end_file(8'hAA);
    // linear base at the top, record that fits nowhere
    push_str(":FF000004FFFF00\n:01FFFF00AA00\n");
    end_file(8'h01);
    // bare end of file
    end_file(8'hFE);

    base_count = items_sent;
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      wait_idle();
      apply_setting(k);
      if (k == PRESSURE_SET) hold_req = 1'b1;
      while (items_sent - base_count < RANDOM_ITEMS * (k + 1) / NUM_SETTINGS)
        random_file();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ihex_pkg.sv
rtl/ihex_in_if.sv
rtl/ihex_out_if.sv
rtl/ihex_cfg_if.sv
rtl/ihex_window.sv
rtl/intel_hex_record_loader_core.sv
tb/intel_hex_record_loader_checker.sv
tb/intel_hex_record_loader_core_test.sv
